// ===== sv/bmfg_pkg.sv =====
// bmfg_pkg: shared types and codes for the four-gamete checker
// item and result payloads, mode and status codes, scan unit control
// no dependencies
package bmfg_pkg;

	// width of the column count register and of the effective count
	localparam int CNT_W = 7;
	localparam int ROW_W = 64;
	localparam int COL_W = 6;

	typedef enum logic [1:0] {
		MODE_CLEAR,
		MODE_APPEND,
		MODE_QUERY,
		MODE_CHECK
	} mode_t;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_FULL  = 2'd1;
	localparam logic [1:0] STATUS_RANGE = 2'd2;

	typedef struct packed {
		mode_t              mode;
		logic [ROW_W-1:0]   row_bits;
		logic [COL_W-1:0]   col_a;
		logic [COL_W-1:0]   col_b;
	} item_t;

	typedef struct packed {
		logic       conflict;
		logic       contained;
		logic       disjoint;
		logic       conflict_free;
		logic [1:0] status;
	} result_t;

	// control of the pattern accumulator
	typedef struct packed {
		logic clear;
		logic enable;
	} acc_ctrl_t;

endpackage

// ===== sv/binary_matrix_four_gamete_checker_unit.sv =====
// Four-gamete checker over a stored binary matrix. Clear and append answer at once; an
// append to a full store drops the row with status 1, and a pair query with a column at
// or above the column count answers status 2 at once. A pair query walks the R stored rows
// through one memory read port, one row a cycle. The whole-matrix check makes one such
// pass per pivot column, testing the pivot against all higher columns at once, and stops
// early at the first conflicting pair. The block takes no item while a scan runs. The store
// needs no clearing pass after reset. The user must write column_count only while idle;
// the block itself does not enforce it.
module binary_matrix_four_gamete_checker_unit #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [bmfg_pkg::CNT_W-1:0] cfg_data,
	input  logic                      item_valid,
	output logic                      item_stall,
	input  bmfg_pkg::item_t           item,
	output logic                      result_valid,
	input  logic                      result_stall,
	output bmfg_pkg::result_t         result
);
	import bmfg_pkg::*;

	localparam int RCW = $clog2(MAX_ROWS + 1);
	localparam int AW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CIW = $clog2(MAX_COLS);

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

	state_t             state_q;
	logic [RCW-1:0]     row_count_q;
	logic [RCW-1:0]     addr_q;
	logic [CNT_W-1:0]   column_count_q;
	logic [CIW-1:0]     col_q;
	logic [CIW-1:0]     colb_q;
	logic               chk_q;
	logic               rd_vld_s1;
	logic [MAX_COLS-1:0] rd_data_s1;
	logic               result_valid_q;
	result_t            result_q;

	logic [MAX_COLS-1:0] rows_mem [MAX_ROWS];

	logic               item_accept;
	logic               result_take;
	logic               full;
	logic [CNT_W-1:0]   n_eff;
	logic               col_bad;
	logic               wr_en;
	logic               rd_en;
	logic               pass_end;
	logic               scan_done;
	logic               last_col;
	logic               any_conf;
	logic               pair_conf;
	logic [MAX_COLS-1:0] upper_mask;
	logic [MAX_COLS-1:0] p11;
	logic [MAX_COLS-1:0] p10;
	logic [MAX_COLS-1:0] p01;
	acc_ctrl_t          acc_ctrl;
	logic               result_load;
	result_t            result_d;

	// handshakes
	assign cfg_ready    = 1'b1;
	assign item_stall   = (state_q != ST_IDLE) || (result_valid_q && result_stall);
	assign item_accept  = item_valid && !item_stall;
	assign result_take  = result_valid_q && !result_stall;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// effective column count and index range check
	assign n_eff   = (column_count_q > CNT_W'(MAX_COLS)) ? CNT_W'(MAX_COLS) : column_count_q;
	assign col_bad = (CNT_W'(item.col_a) >= n_eff) || (CNT_W'(item.col_b) >= n_eff);
	assign full    = (row_count_q == RCW'(MAX_ROWS));

	// memory port controls
	assign wr_en = item_accept && (item.mode == MODE_APPEND) && !full;
	assign rd_en = (state_q == ST_SCAN) && (addr_q != row_count_q);

	// row store, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			rows_mem[row_count_q[AW-1:0]] <= item.row_bits[MAX_COLS-1:0];
		end
		if (rd_en) begin
			rd_data_s1 <= rows_mem[addr_q[AW-1:0]];
		end
	end

	// pass end: every row issued and the last one accumulated
	assign pass_end = (state_q == ST_SCAN) && (addr_q == row_count_q) && !rd_vld_s1;

	// columns above the pivot that are in use
	always_comb begin
		for (int j = 0; j < MAX_COLS; j++) begin
			upper_mask[j] = (CNT_W'(j) > CNT_W'(col_q)) && (CNT_W'(j) < n_eff);
		end
	end

	assign any_conf  = |(p11 & p10 & p01 & upper_mask);
	assign pair_conf = p11[colb_q] & p10[colb_q] & p01[colb_q];
	assign last_col  = (CNT_W'(col_q) + CNT_W'(1)) >= n_eff;
	assign scan_done = pass_end && (!chk_q || any_conf || last_col);

	// clear on scan start and between pivot passes, accumulate each returned row
	assign acc_ctrl.clear  = (item_accept && (((item.mode == MODE_QUERY) && !col_bad)
		|| (item.mode == MODE_CHECK))) || (pass_end && !scan_done);
	assign acc_ctrl.enable = rd_vld_s1;

	bmfg_pattern_acc #(
		.COLS (MAX_COLS),
		.CIW  (CIW)
	) u_acc (
		.clk   (clk),
		.ctrl  (acc_ctrl),
		.pivot (col_q),
		.row   (rd_data_s1),
		.p11   (p11),
		.p10   (p10),
		.p01   (p01)
	);

	// next result and when it is loaded
	always_comb begin
		result_load = 1'b0;
		result_d    = '0;
		if (state_q == ST_IDLE) begin
			if (item_accept) begin
				case (item.mode)
					MODE_CLEAR: begin
						result_load = 1'b1;
					end
					MODE_APPEND: begin
						result_load = 1'b1;
						if (full) begin
							result_d.status = STATUS_FULL;
						end
					end
					MODE_QUERY: begin
						if (col_bad) begin
							result_load     = 1'b1;
							result_d.status = STATUS_RANGE;
						end
					end
					default: begin
					end
				endcase
			end
		end else if (scan_done) begin
			result_load = 1'b1;
			if (chk_q) begin
				result_d.conflict_free = !any_conf;
			end else begin
				result_d.conflict  = pair_conf;
				result_d.contained = !p10[colb_q];
				result_d.disjoint  = !p11[colb_q];
			end
		end
	end

	// sequencer, counters and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			row_count_q    <= '0;
			addr_q         <= '0;
			column_count_q <= CNT_W'(64);
			col_q          <= '0;
			colb_q         <= '0;
			chk_q          <= 1'b0;
			rd_vld_s1      <= 1'b0;
			result_valid_q <= 1'b0;
			result_q       <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				column_count_q <= cfg_data;
			end
			rd_vld_s1 <= rd_en;
			if (rd_en) begin
				addr_q <= addr_q + RCW'(1);
			end
			// load a new result or release the taken one
			if (result_load) begin
				result_valid_q <= 1'b1;
				result_q       <= result_d;
			end else if (result_take) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (item_accept) begin
						case (item.mode)
							MODE_CLEAR: begin
								row_count_q <= '0;
							end
							MODE_APPEND: begin
								if (!full) begin
									row_count_q <= row_count_q + RCW'(1);
								end
							end
							MODE_QUERY: begin
								if (!col_bad) begin
									state_q <= ST_SCAN;
									addr_q  <= '0;
									col_q   <= item.col_a[CIW-1:0];
									colb_q  <= item.col_b[CIW-1:0];
									chk_q   <= 1'b0;
								end
							end
							MODE_CHECK: begin
								state_q <= ST_SCAN;
								addr_q  <= '0;
								col_q   <= '0;
								chk_q   <= 1'b1;
							end
							default: begin
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (scan_done) begin
						state_q <= ST_IDLE;
					end else if (pass_end) begin
						// next pivot column
						col_q  <= col_q + CIW'(1);
						addr_q <= '0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// a finished scan always finds the result register free
	assert property (@(posedge clk) disable iff (!arst_n) scan_done |-> !result_valid_q)
		else $error("scan finished while a result was still pending");

	// the read address never runs past the stored rows
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (addr_q <= row_count_q))
		else $error("read address beyond row count");

	// a dropped row leaves the count alone, and the count stays within the store
	assert property (@(posedge clk) disable iff (!arst_n)
		(item_accept && (item.mode == MODE_APPEND) && full) |=>
		($stable(row_count_q) && (row_count_q == RCW'(MAX_ROWS))))
		else $error("append to full store changed row count");

	// clearing the accumulator never coincides with a returning row
	assert property (@(posedge clk) disable iff (!arst_n) acc_ctrl.clear |-> !acc_ctrl.enable)
		else $error("accumulator cleared while a row was returning");

endmodule

// ===== sv/bmfg_pattern_acc.sv =====
// bmfg_pattern_acc: per-column pattern accumulator used by every scan
// one stored row per cycle, when enabled, against a pivot column; depends on bmfg_pkg
module bmfg_pattern_acc #(
	parameter int COLS = 64,
	parameter int CIW  = 6
) (
	input  logic                clk,
	input  bmfg_pkg::acc_ctrl_t ctrl,
	input  logic [CIW-1:0]      pivot,
	input  logic [COLS-1:0]     row,
	output logic [COLS-1:0]     p11,
	output logic [COLS-1:0]     p10,
	output logic [COLS-1:0]     p01
);
	import bmfg_pkg::*;

	logic [COLS-1:0] p11_q;
	logic [COLS-1:0] p10_q;
	logic [COLS-1:0] p01_q;
	logic            pivot_bit;

	// pivot column value of the current row
	assign pivot_bit = row[pivot];

	// bit j records pivot/column j patterns seen so far
	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			p11_q <= '0;
			p10_q <= '0;
			p01_q <= '0;
		end else if (ctrl.enable) begin
			if (pivot_bit) begin
				p11_q <= p11_q | row;
				p10_q <= p10_q | ~row;
			end else begin
				p01_q <= p01_q | row;
			end
		end
	end

	assign p11 = p11_q;
	assign p10 = p10_q;
	assign p01 = p01_q;

endmodule

// ===== sim/tb_binary_matrix_four_gamete_checker_unit.sv =====
// testbench for binary_matrix_four_gamete_checker_unit: directed and random item streams
// checked against an in-bench predictor of the stored matrix and its column-pair tests
// depends on bmfg_pkg and the checker unit
`timescale 1ns / 100ps

module tb_binary_matrix_four_gamete_checker_unit;
	import bmfg_pkg::*;

	localparam int ROWS_MAX         = 64;
	localparam int COLS_MAX         = 64;
	localparam int RANDOM_ITEMS_END = 370;
	localparam int WATCHDOG_LIMIT   = 20000;
	localparam int TAIL_CYCLES      = 40;

	typedef enum int {
		ROW_RANDOM,
		ROW_PREFIX,
		ROW_SPARSE,
		ROW_NESTED
	} row_style_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [CNT_W-1:0] cfg_data;
	logic        item_valid;
	logic        item_stall;
	item_t       item;
	logic        result_valid;
	logic        result_stall;
	result_t     result;

	// shadow copy of the block state
	logic [ROW_W-1:0] shadow_rows [ROWS_MAX];
	int               shadow_count;
	int               shadow_cols;

	result_t pending_results [$];
	int      errors;
	int      items_sent;
	bit      calm;
	int      stall_left;

	binary_matrix_four_gamete_checker_unit #(
		.MAX_ROWS(ROWS_MAX),
		.MAX_COLS(COLS_MAX)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	// clock
	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [5:0] rand6();
		return 6'($urandom_range(0, 63));
	endfunction

	function automatic int usable_cols();
		return (shadow_cols > COLS_MAX) ? COLS_MAX : shadow_cols;
	endfunction

	// pattern flags of one column pair over the stored rows
	task automatic pair_patterns(input int a, input int b, output bit s11, output bit s10,
			output bit s01);
		s11 = 1'b0;
		s10 = 1'b0;
		s01 = 1'b0;
		for (int i = 0; i < shadow_count; i++) begin
			s11 |= shadow_rows[i][a] & shadow_rows[i][b];
			s10 |= shadow_rows[i][a] & ~shadow_rows[i][b];
			s01 |= ~shadow_rows[i][a] & shadow_rows[i][b];
		end
	endtask

	// pivot column against all higher columns at once, bitwise over the rows
	function automatic bit matrix_conflict_free(int n);
		logic [63:0] seen11, seen10, seen01, higher;
		for (int c = 0; c < n; c++) begin
			seen11 = '0;
			seen10 = '0;
			seen01 = '0;
			for (int i = 0; i < shadow_count; i++) begin
				if (shadow_rows[i][c]) begin
					seen11 |= shadow_rows[i];
					seen10 |= ~shadow_rows[i];
				end else begin
					seen01 |= shadow_rows[i];
				end
			end
			higher = ((64'd1 << n) - 64'd1) & ~((64'd1 << (c + 1)) - 64'd1);
			if ((seen11 & seen10 & seen01 & higher) != '0)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	// apply one item to the shadow state and queue the result it should give
	task automatic predict_gamete_result(item_t it);
		result_t r;
		int      n;
		bit      s11, s10, s01;
		r = '0;
		n = usable_cols();
		case (it.mode)
			MODE_CLEAR: begin
				shadow_count = 0;
			end
			MODE_APPEND: begin
				if (shadow_count >= ROWS_MAX) begin
					r.status = STATUS_FULL;
				end else begin
					shadow_rows[shadow_count] = it.row_bits;
					shadow_count++;
				end
			end
			MODE_QUERY: begin
				if (int'(it.col_a) >= n || int'(it.col_b) >= n) begin
					r.status = STATUS_RANGE;
				end else begin
					pair_patterns(int'(it.col_a), int'(it.col_b), s11, s10, s01);
					r.conflict  = s11 & s10 & s01;
					r.contained = ~s10;
					r.disjoint  = ~s11;
				end
			end
			default: begin
				r.conflict_free = matrix_conflict_free(n);
			end
		endcase
		pending_results.push_back(r);
	endtask

	function automatic logic [63:0] make_row(row_style_t style, int n);
		logic [63:0] used, r;
		used = (64'd1 << n) - 64'd1;
		case (style)
			ROW_RANDOM: r = rand64();
			ROW_PREFIX: r = (64'd1 << $urandom_range(0, 64)) - 64'd1;
			ROW_SPARSE: r = $urandom_range(0, 1) ? (64'd1 << $urandom_range(0, 63)) : 64'd0;
			default:    r = ((64'd1 << $urandom_range(0, 64)) - 64'd1)
					^ (64'd1 << $urandom_range(0, 63));
		endcase
		// bits at or above the column count are stored but never affect a result
		return (r & used) | (rand64() & ~used);
	endfunction

	// one item transfer, with an optional idle burst ahead of it
	task automatic send_item(item_t it);
		int gap;
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 3);
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		predict_gamete_result(it);
		item       <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		items_sent++;
	endtask

	task automatic send_op(mode_t m, logic [63:0] row, logic [5:0] a, logic [5:0] b);
		item_t it;
		it.mode     = m;
		it.row_bits = row;
		it.col_a    = a;
		it.col_b    = b;
		send_item(it);
	endtask

	// wait until every queued result has been taken
	task automatic drain_results();
		item_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic write_column_count(logic [CNT_W-1:0] value);
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid   <= 1'b0;
		shadow_cols = int'(value);
	endtask

	// maybe a clear, a run of appends, some pair queries, maybe a check, maybe noise
	task automatic run_sequence(bit fill);
		int         appends;
		int         queries;
		int         n;
		row_style_t style;
		n     = usable_cols();
		style = row_style_t'($urandom_range(0, 3));
		if ($urandom_range(0, 7) != 0)
			send_op(MODE_CLEAR, rand64(), rand6(), rand6());
		if (fill || $urandom_range(0, 9) == 0)
			appends = $urandom_range(60, 72);
		else
			appends = $urandom_range(0, 10);
		repeat (appends) send_op(MODE_APPEND, make_row(style, n), rand6(), rand6());
		queries = $urandom_range(1, 5);
		repeat (queries) begin
			if (n > 0 && $urandom_range(0, 4) != 0)
				send_op(MODE_QUERY, rand64(), 6'($urandom_range(0, n - 1)),
					6'($urandom_range(0, n - 1)));
			else
				send_op(MODE_QUERY, rand64(), rand6(), rand6());
		end
		if ($urandom_range(0, 1) != 0)
			send_op(MODE_CHECK, rand64(), rand6(), rand6());
		if ($urandom_range(0, 4) == 0)
			send_op(mode_t'($urandom_range(0, 3)), rand64(), rand6(), rand6());
	endtask

	task automatic test_empty_store();
		write_column_count(7'd64);
		send_op(MODE_CLEAR, rand64(), rand6(), rand6());
		send_op(MODE_QUERY, rand64(), 6'd0, 6'd63);
		send_op(MODE_QUERY, rand64(), 6'd5, 6'd5);
		send_op(MODE_CHECK, rand64(), rand6(), rand6());
	endtask

	task automatic test_pair_patterns();
		send_op(MODE_APPEND, 64'h3, rand6(), rand6());
		send_op(MODE_APPEND, 64'h1, rand6(), rand6());
		send_op(MODE_APPEND, 64'h2, rand6(), rand6());
		send_op(MODE_APPEND, '1, rand6(), rand6());
		send_op(MODE_APPEND, '0, rand6(), rand6());
		send_op(MODE_QUERY, rand64(), 6'd0, 6'd1);
		send_op(MODE_QUERY, rand64(), 6'd1, 6'd0);
		send_op(MODE_QUERY, rand64(), 6'd0, 6'd2);
		send_op(MODE_QUERY, rand64(), 6'd2, 6'd0);
		send_op(MODE_QUERY, rand64(), 6'd63, 6'd63);
		send_op(MODE_CHECK, rand64(), rand6(), rand6());
	endtask

	task automatic test_column_range();
		drain_results();
		write_column_count(7'd2);
		send_op(MODE_QUERY, rand64(), 6'd1, 6'd2);
		send_op(MODE_QUERY, rand64(), 6'd0, 6'd1);
		send_op(MODE_CHECK, rand64(), rand6(), rand6());
		drain_results();
		write_column_count(7'd1);
		send_op(MODE_QUERY, rand64(), 6'd0, 6'd0);
		send_op(MODE_CHECK, rand64(), rand6(), rand6());
		drain_results();
		write_column_count(7'd0);
		send_op(MODE_QUERY, rand64(), 6'd0, 6'd0);
		send_op(MODE_CHECK, rand64(), rand6(), rand6());
		drain_results();
		write_column_count(7'd127);
		send_op(MODE_QUERY, rand64(), 6'd63, 6'd0);
		send_op(MODE_CHECK, rand64(), rand6(), rand6());
	endtask

	task automatic test_store_overflow();
		drain_results();
		write_column_count(7'd64);
		run_sequence(1'b1);
	endtask

	task automatic test_random_sequences();
		int phase;
		phase = 0;
		while (items_sent < RANDOM_ITEMS_END) begin
			drain_results();
			case (phase)
				0:       write_column_count(7'd65);
				1:       write_column_count(7'd1);
				2:       write_column_count(7'd0);
				3:       write_column_count(7'd127);
				4:       write_column_count(7'd2);
				default: begin
					if ($urandom_range(0, 3) == 0)
						write_column_count(7'($urandom_range(0, 127)));
					else
						write_column_count(7'($urandom_range(2, 64)));
				end
			endcase
			run_sequence(1'b0);
			phase++;
		end
	endtask

	// last stretch runs with no idling on either side
	task automatic test_calm_tail();
		drain_results();
		calm = 1'b1;
		write_column_count(7'($urandom_range(2, 64)));
		run_sequence(1'b0);
		run_sequence(1'b0);
	endtask

	task automatic compare_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			errors++;
		end
	endtask

	// result checker
	always @(posedge clk) begin : result_monitor
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result with none expected, expected none, actual %h",
					$time, result);
				errors++;
			end else begin
				want = pending_results.pop_front();
				compare_field("conflict", 32'(want.conflict), 32'(result.conflict));
				compare_field("contained", 32'(want.contained), 32'(result.contained));
				compare_field("disjoint", 32'(want.disjoint), 32'(result.disjoint));
				compare_field("conflict_free", 32'(want.conflict_free),
					32'(result.conflict_free));
				compare_field("status", 32'(want.status), 32'(result.status));
			end
		end
	end

	// receiver stall bursts
	always @(posedge clk) begin
		if (!arst_n || calm) begin
			result_stall <= 1'b0;
		end else if (stall_left > 0) begin
			result_stall <= 1'b1;
			stall_left--;
		end else if ($urandom_range(0, 5) == 0) begin
			result_stall <= 1'b1;
			stall_left = $urandom_range(0, 2);
		end else begin
			result_stall <= 1'b0;
		end
	end

	// watchdog on cycles without any transfer
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall)
					|| (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb_binary_matrix_four_gamete_checker_unit failed");
		$finish;
	end

	// main sequence
	initial begin
		arst_n       = 1'b0;
		cfg_valid    = 1'b0;
		cfg_data     = '0;
		item_valid   = 1'b0;
		item         = '0;
		items_sent   = 0;
		calm         = 1'b0;
		shadow_count = 0;
		shadow_cols  = 64;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_store();
		test_pair_patterns();
		test_column_range();
		test_store_overflow();
		test_random_sequences();
		test_calm_tail();
		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0)
			$display("tb_binary_matrix_four_gamete_checker_unit passed");
		else
			$display("tb_binary_matrix_four_gamete_checker_unit failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/bmfg_pkg.sv
sv/bmfg_pattern_acc.sv
sv/binary_matrix_four_gamete_checker_unit.sv
sim/tb_binary_matrix_four_gamete_checker_unit.sv
